@@ rtl/sld_pkg.sv @@
// Package for the sync/length/CRC frame decoder.
// Holds the controller state type, the command and status structs, the
// frame constants and the CRC-16/CCITT-FALSE byte update. No dependencies.
package sld_pkg;

    localparam logic [7:0]  SYNC_FIRST   = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND  = 8'h55;
    localparam int          HEADER_BYTES = 3;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'h1021;

    typedef enum logic [3:0] {
        ST_HUNT0,
        ST_HUNT1,
        ST_LEN_HI,
        ST_LEN_LO,
        ST_BODY,
        ST_CRC_HI,
        ST_CRC_LO,
        ST_EMIT_READ,
        ST_EMIT_LOAD
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_len_hi;
        logic start_frame;
        logic take_body;
        logic take_crc_hi;
        logic clear_frame;
        logic emit_first;
        logic emit_read;
        logic emit_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sync_first;
        logic sync_second;
        logic len_ok;
        logic body_last;
        logic crc_ok;
        logic emit_last;
        logic out_free;
    } stat_t;

    // One byte of CRC-16/CCITT-FALSE, MSB first.
    function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                 input logic [7:0]  data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ rtl/sld_rx_if.sv @@
// Input channel of the frame decoder: one received byte per transaction.
// Standalone valid/ready interface, no dependencies.
interface sld_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ rtl/sld_frame_if.sv @@
// Output channel of the frame decoder: one decoded payload result per transaction.
// Standalone valid/ready interface, no dependencies.
interface sld_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_addr;
    logic [7:0] frame_seq;
    logic [7:0] frame_kind;
    logic [6:0] payload_count;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;

    modport source (output valid, output frame_addr, output frame_seq, output frame_kind,
                    output payload_count, output data_byte, output byte_valid,
                    output last, input ready);
    modport sink   (input valid, input frame_addr, input frame_seq, input frame_kind,
                    input payload_count, input data_byte, input byte_valid,
                    input last, output ready);
endinterface

@@ rtl/sld_ctrl.sv @@
// Controller state machine of the frame decoder.
// Depends on sld_pkg; drives the datapath through cmd_t and reads stat_t.
module sld_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           rx_valid,
    output logic           rx_ready,
    input  sld_pkg::stat_t stat,
    output sld_pkg::cmd_t  cmd
);
    import sld_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign rx_ready = (state_reg != ST_EMIT_READ) && (state_reg != ST_EMIT_LOAD);
    assign accept   = rx_valid && rx_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_HUNT0:
            begin
                if (accept && stat.sync_first)
                begin
                    state_next = ST_HUNT1;
                end
            end
            ST_HUNT1:
            begin
                if (accept)
                begin
                    if (stat.sync_second)
                    begin
                        state_next = ST_LEN_HI;
                    end
                    else if (!stat.sync_first)
                    begin
                        state_next = ST_HUNT0;
                    end
                end
            end
            ST_LEN_HI:
            begin
                if (accept)
                begin
                    state_next = ST_LEN_LO;
                end
            end
            ST_LEN_LO:
            begin
                if (accept)
                begin
                    state_next = stat.len_ok ? ST_BODY : ST_HUNT0;
                end
            end
            ST_BODY:
            begin
                if (accept && stat.body_last)
                begin
                    state_next = ST_CRC_HI;
                end
            end
            ST_CRC_HI:
            begin
                if (accept)
                begin
                    state_next = ST_CRC_LO;
                end
            end
            ST_CRC_LO:
            begin
                if (accept)
                begin
                    state_next = stat.crc_ok ? ST_EMIT_READ : ST_HUNT0;
                end
            end
            ST_EMIT_READ:
            begin
                state_next = ST_EMIT_LOAD;
            end
            ST_EMIT_LOAD:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.emit_last ? ST_HUNT0 : ST_EMIT_READ;
                end
            end
            default:
            begin
                state_next = ST_HUNT0;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_LEN_HI:
            begin
                cmd.take_len_hi = accept;
            end
            ST_LEN_LO:
            begin
                cmd.start_frame = accept && stat.len_ok;
                cmd.clear_frame = accept && !stat.len_ok;
            end
            ST_BODY:
            begin
                cmd.take_body = accept;
            end
            ST_CRC_HI:
            begin
                cmd.take_crc_hi = accept;
            end
            ST_CRC_LO:
            begin
                cmd.emit_first  = accept && stat.crc_ok;
                cmd.clear_frame = accept && !stat.crc_ok;
            end
            ST_EMIT_READ:
            begin
                cmd.emit_read = 1'b1;
            end
            ST_EMIT_LOAD:
            begin
                cmd.emit_load   = stat.out_free;
                cmd.clear_frame = stat.out_free && stat.emit_last;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // A result is only loaded when the output register can take it.
    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_load |-> stat.out_free)
        else $error("result loaded into a busy output register");

    // The final result of a frame returns the decoder to the hunt.
    a_last_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT_LOAD && stat.out_free && stat.emit_last)
        |=> state_reg == ST_HUNT0)
        else $error("decoder did not return to hunt after last result");

    // The final body byte moves the decoder to the CRC bytes.
    a_body_to_crc: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take_body && stat.body_last) |=> state_reg == ST_CRC_HI)
        else $error("decoder missed the end of the body");

    // Datapath commands that move data never overlap.
    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.take_len_hi, cmd.take_body, cmd.take_crc_hi,
                  cmd.emit_read, cmd.emit_load}))
        else $error("overlapping datapath commands");

endmodule

@@ rtl/sld_datapath.sv @@
// Datapath of the frame decoder: length, fill counter, running CRC, header
// registers, payload memory, emission counter and the output register.
// Depends on sld_pkg, sld_frame_if; commanded by sld_ctrl.
module sld_datapath #(
    parameter int MAX_PAYLOAD_BYTES = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [7:0]     rx_byte,
    input  sld_pkg::cmd_t  cmd,
    output sld_pkg::stat_t stat,
    sld_frame_if.source    frame
);
    import sld_pkg::*;

    localparam int BODY_DEPTH = HEADER_BYTES + MAX_PAYLOAD_BYTES;
    localparam int LEN_W      = $clog2(BODY_DEPTH + 1);
    localparam int PAY_AW     = (MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1;

    logic [7:0]        len_hi_reg;
    logic [LEN_W-1:0]  body_len_reg;
    logic [LEN_W-1:0]  fill_count_reg;
    logic [15:0]       running_crc_reg;
    logic [7:0]        crc_hi_reg;
    logic [7:0]        addr_reg;
    logic [7:0]        seq_reg;
    logic [7:0]        kind_reg;
    logic [PAY_AW-1:0] emit_idx_reg;
    logic [7:0]        rd_data_reg;

    logic [7:0] payload_mem [MAX_PAYLOAD_BYTES];

    logic              out_valid_reg;
    logic [7:0]        out_addr_reg;
    logic [7:0]        out_seq_reg;
    logic [7:0]        out_kind_reg;
    logic [6:0]        out_count_reg;
    logic [7:0]        out_data_reg;
    logic              out_bvalid_reg;
    logic              out_last_reg;

    logic [15:0]       len_full;
    logic [LEN_W-1:0]  fill_minus_hdr;
    logic [PAY_AW-1:0] wr_addr;
    logic [LEN_W-1:0]  plen;
    logic [15:0]       plen_wide;
    logic              plen_zero;

    assign len_full       = {len_hi_reg, rx_byte};
    assign fill_minus_hdr = fill_count_reg - LEN_W'(HEADER_BYTES);
    assign wr_addr        = fill_minus_hdr[PAY_AW-1:0];
    assign plen           = body_len_reg - LEN_W'(HEADER_BYTES);
    assign plen_wide      = 16'(plen);
    assign plen_zero      = (plen == '0);

    always_comb
    begin
        stat.sync_first  = (rx_byte == SYNC_FIRST);
        stat.sync_second = (rx_byte == SYNC_SECOND);
        stat.len_ok      = (len_full >= 16'(HEADER_BYTES))
                           && (17'(len_full) <= 17'(BODY_DEPTH));
        stat.body_last   = ({1'b0, fill_count_reg} + (LEN_W + 1)'(1))
                           >= {1'b0, body_len_reg};
        stat.crc_ok      = ({crc_hi_reg, rx_byte} == running_crc_reg);
        stat.emit_last   = plen_zero || ((LEN_W'(emit_idx_reg) + LEN_W'(1)) == plen);
        stat.out_free    = !out_valid_reg || frame.ready;
    end

    // Frame bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            body_len_reg    <= '0;
            fill_count_reg  <= '0;
            running_crc_reg <= CRC_INIT;
            emit_idx_reg    <= '0;
        end
        else
        begin
            if (cmd.clear_frame)
            begin
                body_len_reg    <= '0;
                fill_count_reg  <= '0;
                running_crc_reg <= CRC_INIT;
            end
            else if (cmd.start_frame)
            begin
                body_len_reg    <= len_full[LEN_W-1:0];
                fill_count_reg  <= '0;
                running_crc_reg <= CRC_INIT;
            end
            else if (cmd.take_body)
            begin
                fill_count_reg  <= fill_count_reg + LEN_W'(1);
                running_crc_reg <= crc16_update(running_crc_reg, rx_byte);
            end

            if (cmd.emit_first)
            begin
                emit_idx_reg <= '0;
            end
            else if (cmd.emit_load && !stat.emit_last)
            begin
                emit_idx_reg <= emit_idx_reg + PAY_AW'(1);
            end
        end
    end

    // Captured bytes; meaningful only after they are written in a frame.
    always_ff @(posedge clk)
    begin
        if (cmd.take_len_hi)
        begin
            len_hi_reg <= rx_byte;
        end
        if (cmd.take_crc_hi)
        begin
            crc_hi_reg <= rx_byte;
        end
        if (cmd.take_body)
        begin
            if (fill_count_reg == LEN_W'(0))
            begin
                addr_reg <= rx_byte;
            end
            if (fill_count_reg == LEN_W'(1))
            begin
                seq_reg <= rx_byte;
            end
            if (fill_count_reg == LEN_W'(2))
            begin
                kind_reg <= rx_byte;
            end
        end
    end

    // Payload memory, one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.take_body && (fill_count_reg >= LEN_W'(HEADER_BYTES)))
        begin
            payload_mem[wr_addr] <= rx_byte;
        end
        if (cmd.emit_read)
        begin
            rd_data_reg <= payload_mem[emit_idx_reg];
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (frame.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            out_addr_reg   <= addr_reg;
            out_seq_reg    <= seq_reg;
            out_kind_reg   <= kind_reg;
            out_count_reg  <= plen_wide[6:0];
            out_data_reg   <= plen_zero ? 8'h00 : rd_data_reg;
            out_bvalid_reg <= !plen_zero;
            out_last_reg   <= stat.emit_last;
        end
    end

    assign frame.valid         = out_valid_reg;
    assign frame.frame_addr    = out_addr_reg;
    assign frame.frame_seq     = out_seq_reg;
    assign frame.frame_kind    = out_kind_reg;
    assign frame.payload_count = out_count_reg;
    assign frame.data_byte     = out_data_reg;
    assign frame.byte_valid    = out_bvalid_reg;
    assign frame.last          = out_last_reg;

endmodule

@@ rtl/sync_len_crc_frame_decoder_top.sv @@
// Top level of the sync/length/CRC-16 frame decoder.
// Depends on sld_pkg, sld_rx_if, sld_frame_if, sld_ctrl and sld_datapath.
//
// Usage: the rx channel carries one received byte per transaction. The block
// hunts for the sync pair 0xAA 0x55, reads a big-endian body length, stores
// the body (address, sequence, type, payload) and checks the big-endian
// CRC-16/CCITT-FALSE that follows. The frame channel carries one transaction
// per payload byte of a good frame, or one transaction with byte_valid low
// for an empty payload; the final one has last set. Bad frames vanish.
//
// Throughput: one byte per cycle while a frame is received. After a good
// frame's last CRC byte, rx ready drops and the emission sequencer gives
// each result a payload memory read, then an output register load once that
// register is free. The first read directly follows the last CRC byte, and
// rx ready returns in the cycle after the final result is loaded.
//
// A stalled frame sink holds the output register and the sequencer waits;
// rx stays stalled only while results are still being loaded. Reset returns
// the controller to the hunt and empties the output register; the payload
// memory needs no clearing because only entries written by the frame reach the output.
module sync_len_crc_frame_decoder_top #(
    parameter int MAX_PAYLOAD_BYTES = 64
) (
    input logic         clk,
    input logic         rst_n,
    sld_rx_if.sink      rx,
    sld_frame_if.source frame
);
    import sld_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Controller decides what each accepted byte means.
    sld_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx.valid),
        .rx_ready (rx.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath holds the frame contents and drives the result channel.
    sld_datapath #(
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx_byte (rx.rx_byte),
        .cmd     (cmd),
        .stat    (stat),
        .frame   (frame)
    );

endmodule
